[rtl/mso_pkg.sv]
// mso_pkg: shared constants, codes and case tables for the marching-squares outline block.
// No dependencies; compiled first.
package mso_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int INDEX_BITS_DEF = 20;
    localparam int MAX_ROWS       = 1024;
    localparam int ROW_BITS       = 10;
    localparam int DIM_W          = 11;
    localparam int SCALE_W        = 32;
    localparam int IDX_FIELD_W    = 20;
    localparam int POS_W          = 42;
    localparam int CFG_IDX_W      = 2;
    localparam int MAX_RESULTS    = 6;
    localparam int REC_CNT_W      = 3;

    localparam logic [DIM_W-1:0]   GRID_WIDTH_RST  = 11'd2;
    localparam logic [DIM_W-1:0]   GRID_HEIGHT_RST = 11'd2;
    localparam logic [SCALE_W-1:0] CELL_SCALE_RST  = 32'h0001_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_WIDTH  = 2'd0,
        REG_GRID_HEIGHT = 2'd1,
        REG_CELL_SCALE  = 2'd2
    } cfg_reg_t;

    // edge midpoints of one square
    typedef enum logic [1:0] {
        EDGE_B = 2'd0,
        EDGE_L = 2'd1,
        EDGE_T = 2'd2,
        EDGE_R = 2'd3
    } edge_t;

    // number of edge midpoints touched by each case
    function automatic logic [2:0] case_len(input logic [3:0] sq);
        logic [2:0] len;
        case (sq)
            4'd0, 4'd15: len = 3'd0;
            4'd5, 4'd10: len = 3'd4;
            default:     len = 3'd2;
        endcase
        return len;
    endfunction

    // e-th edge of a case; segments join entries 0-1 and 2-3
    function automatic edge_t case_edge(input logic [3:0] sq, input logic [1:0] e);
        logic [7:0] lst;
        case (sq)
            4'd1:    lst = {EDGE_B, EDGE_B, EDGE_L, EDGE_B};
            4'd2:    lst = {EDGE_B, EDGE_B, EDGE_R, EDGE_B};
            4'd3:    lst = {EDGE_B, EDGE_B, EDGE_R, EDGE_L};
            4'd4:    lst = {EDGE_B, EDGE_B, EDGE_R, EDGE_T};
            4'd5:    lst = {EDGE_R, EDGE_B, EDGE_T, EDGE_L};
            4'd6:    lst = {EDGE_B, EDGE_B, EDGE_B, EDGE_T};
            4'd7:    lst = {EDGE_B, EDGE_B, EDGE_T, EDGE_L};
            4'd8:    lst = {EDGE_B, EDGE_B, EDGE_T, EDGE_L};
            4'd9:    lst = {EDGE_B, EDGE_B, EDGE_B, EDGE_T};
            4'd10:   lst = {EDGE_R, EDGE_T, EDGE_B, EDGE_L};
            4'd11:   lst = {EDGE_B, EDGE_B, EDGE_R, EDGE_T};
            4'd12:   lst = {EDGE_B, EDGE_B, EDGE_R, EDGE_L};
            4'd13:   lst = {EDGE_B, EDGE_B, EDGE_R, EDGE_B};
            4'd14:   lst = {EDGE_B, EDGE_B, EDGE_B, EDGE_L};
            default: lst = {EDGE_B, EDGE_B, EDGE_B, EDGE_B};
        endcase
        return edge_t'(lst[2*e +: 2]);
    endfunction

endpackage

[rtl/mso_if.sv]
// mso_if: valid/ready channel interfaces for input cells and output records.
// Depends on mso_pkg for field widths.
interface mso_in_if;
    logic valid;
    logic ready;
    logic map_bit;

    modport source (output valid, output map_bit, input ready);
    modport sink   (input valid, input map_bit, output ready);
endinterface

interface mso_out_if;
    logic                             valid;
    logic                             ready;
    logic                             is_segment;
    logic [mso_pkg::IDX_FIELD_W-1:0]  first_index;
    logic [mso_pkg::IDX_FIELD_W-1:0]  second_index;
    logic [mso_pkg::POS_W-1:0]        pos_x;
    logic [mso_pkg::POS_W-1:0]        pos_y;
    logic                             index_overflow;
    logic                             last;

    modport source (output valid, output is_segment, output first_index, output second_index,
                    output pos_x, output pos_y, output index_overflow, output last,
                    input ready);
    modport sink   (input valid, input is_segment, input first_index, input second_index,
                    input pos_x, input pos_y, input index_overflow, input last,
                    output ready);
endinterface

[rtl/mso_ram.sv]
// mso_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module mso_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                   clk,
    input  logic                   we,
    input  logic [AW-1:0]          waddr,
    input  logic [WIDTH-1:0]       wdata,
    input  logic                   re,
    input  logic [AW-1:0]          raddr,
    output logic [WIDTH-1:0]       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

[rtl/marching_squares_outline.sv]
// marching_squares_outline: streaming marching-squares outline of a binary grid.
// Depends on mso_pkg, mso_if (channel interfaces) and mso_ram.
//
// Usage:
//  - in_ch carries one map cell bit per item in raster order, row zero first.
//  - out_ch carries result items: vertex records (new edge midpoint, index and
//    Q16.16 position) followed by segment records (pairs of vertex indices).
//    last marks the final result of the cell that caused it; cells in row 0 or
//    column 0, and empty or full squares, give no results at all.
//  - cfg port: cfg_we/cfg_index/cfg_wdata, written only while idle. Writing
//    grid_width or grid_height restarts the grid; cell_scale only rescales.
// Pipeline: accept (row/vertex memory read issued) -> S1 (read data back)
//  -> record buffer (square decoded, memories written) -> output register
//  (position multiply).
// Throughput: one result per cycle while out_ch.ready is high. A cell holds the
//  record buffer until its results (up to 6) have left; one with none leaves it
//  free. The output register sets the pace: one buffer entry per output slot.
// Reset: counters, vertex count and valid flags clear at once; the row and
//  vertex memories need no clearing pass, since each entry is read only after
//  the row above wrote it.
// Stall: when out_ch.ready is low the output register holds, the record
//  buffer fills, and in_ch.ready drops once S1 also holds an item.
module marching_squares_outline #(
    parameter int MAX_WIDTH  = mso_pkg::MAX_WIDTH_DEF,
    parameter int INDEX_BITS = mso_pkg::INDEX_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [mso_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mso_pkg::SCALE_W-1:0]   cfg_wdata,
    mso_in_if.sink                        in_ch,
    mso_out_if.source                     out_ch
);
    localparam int CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int LW   = ($clog2(MAX_WIDTH + 1) > mso_pkg::DIM_W) ?
                          $clog2(MAX_WIDTH + 1) : mso_pkg::DIM_W;
    localparam int RB   = mso_pkg::ROW_BITS;
    localparam int HXW  = CW + 2;
    localparam int HYW  = RB + 2;
    localparam int TW   = INDEX_BITS + 1;
    localparam int NR   = mso_pkg::MAX_RESULTS;
    localparam int NW   = mso_pkg::REC_CNT_W;
    localparam int PXW  = HXW + mso_pkg::SCALE_W;
    localparam int PYW  = HYW + mso_pkg::SCALE_W;

    // ---------------- configuration ----------------
    logic [mso_pkg::DIM_W-1:0]   grid_width_reg;
    logic [mso_pkg::DIM_W-1:0]   grid_height_reg;
    logic [mso_pkg::SCALE_W-1:0] cell_scale_reg;
    logic                        restart;

    assign restart = cfg_we &&
        ((cfg_index == mso_pkg::REG_GRID_WIDTH) || (cfg_index == mso_pkg::REG_GRID_HEIGHT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= mso_pkg::GRID_WIDTH_RST;
            grid_height_reg <= mso_pkg::GRID_HEIGHT_RST;
            cell_scale_reg  <= mso_pkg::CELL_SCALE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mso_pkg::REG_GRID_WIDTH:  grid_width_reg  <= cfg_wdata[mso_pkg::DIM_W-1:0];
                mso_pkg::REG_GRID_HEIGHT: grid_height_reg <= cfg_wdata[mso_pkg::DIM_W-1:0];
                mso_pkg::REG_CELL_SCALE:  cell_scale_reg  <= cfg_wdata;
                default:                  ;
            endcase
        end
    end

    // clamped grid size
    logic [LW-1:0]             eff_w;
    logic [mso_pkg::DIM_W-1:0] eff_h;

    always_comb
    begin
        eff_w = LW'(grid_width_reg);
        if (eff_w < LW'(2))
        begin
            eff_w = LW'(2);
        end
        else if (eff_w > LW'(MAX_WIDTH))
        begin
            eff_w = LW'(MAX_WIDTH);
        end
        eff_h = grid_height_reg;
        if (eff_h < mso_pkg::DIM_W'(2))
        begin
            eff_h = mso_pkg::DIM_W'(2);
        end
        else if (eff_h > mso_pkg::DIM_W'(mso_pkg::MAX_ROWS))
        begin
            eff_h = mso_pkg::DIM_W'(mso_pkg::MAX_ROWS);
        end
    end

    // ---------------- accept side: raster position ----------------
    logic            in_accept;
    logic [CW-1:0]   col_reg, col_next;
    logic [RB-1:0]   row_reg, row_next;
    logic            wrap_col, wrap_row;
    logic            xfer;
    logic            s1_valid_reg;

    assign in_accept   = in_ch.valid && in_ch.ready;
    assign in_ch.ready = !s1_valid_reg || xfer;
    assign wrap_col    = (LW'(col_reg) + LW'(1)) >= eff_w;
    assign wrap_row    = (mso_pkg::DIM_W'(row_reg) + mso_pkg::DIM_W'(1)) >= eff_h;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (restart)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (in_accept)
        begin
            if (wrap_col)
            begin
                col_next = '0;
                row_next = wrap_row ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ---------------- memories ----------------
    logic [CW-1:0] top_raddr;
    logic          map_rdata;
    logic [TW-1:0] top_rdata;
    logic          top_we;
    logic [CW-1:0] top_waddr;
    logic [TW-1:0] top_wdata;

    // column 0 completes no square; its top read is a don't-care
    assign top_raddr = (col_reg == '0) ? '0 : col_reg - 1'b1;

    // ---------------- S1: item waiting for its read data ----------------
    logic          s1_bit_reg;
    logic [CW-1:0] s1_col_reg;
    logic [RB-1:0] s1_row_reg;
    logic          s1_eol_reg;
    logic          s1_eog_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (xfer)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_bit_reg <= in_ch.map_bit;
            s1_col_reg <= col_reg;
            s1_row_reg <= row_reg;
            s1_eol_reg <= wrap_col;
            s1_eog_reg <= wrap_col && wrap_row;
        end
    end

    mso_ram #(.WIDTH(1), .DEPTH(MAX_WIDTH)) u_map_ram (
        .clk   (clk),
        .we    (xfer),
        .waddr (s1_col_reg),
        .wdata (s1_bit_reg),
        .re    (in_accept),
        .raddr (col_reg),
        .rdata (map_rdata)
    );

    mso_ram #(.WIDTH(TW), .DEPTH(MAX_WIDTH)) u_top_ram (
        .clk   (clk),
        .we    (top_we),
        .waddr (top_waddr),
        .wdata (top_wdata),
        .re    (in_accept),
        .raddr (top_raddr),
        .rdata (top_rdata)
    );

    // ---------------- square decode (read-modify-write) ----------------
    logic                  prev_cur_reg, prev_above_reg;
    logic                  lr_valid_reg;
    logic [INDEX_BITS-1:0] lr_id_reg;
    logic [INDEX_BITS-1:0] vcount_reg;
    logic                  ovf_seen_reg;

    logic                  has_sq;
    logic [CW-1:0]         sq_x;
    logic [RB-1:0]         sq_y;
    logic [3:0]            sq;
    logic [2:0]            len;
    mso_pkg::edge_t        edg;
    logic [INDEX_BITS-1:0] cnt;
    logic                  ovf;
    logic [NW-1:0]         n;
    logic [INDEX_BITS-1:0] vid [4];
    logic                  has_t, has_r;
    logic [INDEX_BITS-1:0] t_id, r_id;
    logic                  rec_seg [NR];
    logic [INDEX_BITS-1:0] rec_a   [NR];
    logic [INDEX_BITS-1:0] rec_b   [NR];
    logic [HXW-1:0]        rec_hx  [NR];
    logic [HYW-1:0]        rec_hy  [NR];
    logic                  rec_ovf [NR];

    assign has_sq = (s1_row_reg != '0) && (s1_col_reg != '0);
    assign sq_x   = s1_col_reg - 1'b1;
    assign sq_y   = s1_row_reg - 1'b1;
    // bit0 bottom-left, bit1 bottom-right, bit2 top-right, bit3 top-left
    assign sq     = {prev_cur_reg, s1_bit_reg, map_rdata, prev_above_reg};
    assign len    = has_sq ? mso_pkg::case_len(sq) : 3'd0;

    always_comb
    begin
        cnt   = vcount_reg;
        ovf   = ovf_seen_reg;
        n     = '0;
        has_t = 1'b0;
        has_r = 1'b0;
        t_id  = '0;
        r_id  = '0;
        edg   = mso_pkg::EDGE_B;
        for (int e = 0; e < 4; e++)
        begin
            vid[e] = '0;
        end
        for (int k = 0; k < NR; k++)
        begin
            rec_seg[k] = 1'b0;
            rec_a[k]   = '0;
            rec_b[k]   = '0;
            rec_hx[k]  = '0;
            rec_hy[k]  = '0;
            rec_ovf[k] = 1'b0;
        end
        // vertices in table order; shared bottom/left reuse a stored index
        for (int e = 0; e < 4; e++)
        begin
            edg = mso_pkg::case_edge(sq, 2'(e));
            if (3'(e) < len)
            begin
                if (edg == mso_pkg::EDGE_B && sq_y != '0 && top_rdata[TW-1])
                begin
                    vid[e] = top_rdata[INDEX_BITS-1:0];
                end
                else if (edg == mso_pkg::EDGE_L && sq_x != '0 && lr_valid_reg)
                begin
                    vid[e] = lr_id_reg;
                end
                else
                begin
                    vid[e] = cnt;
                    if (cnt != '1)
                    begin
                        cnt = cnt + 1'b1;
                    end
                    else
                    begin
                        ovf = 1'b1;
                    end
                    rec_seg[n] = 1'b0;
                    rec_a[n]   = vid[e];
                    rec_ovf[n] = ovf;
                    case (edg)
                        mso_pkg::EDGE_B:
                        begin
                            rec_hx[n] = HXW'({sq_x, 1'b1});
                            rec_hy[n] = HYW'({sq_y, 1'b0});
                        end
                        mso_pkg::EDGE_L:
                        begin
                            rec_hx[n] = HXW'({sq_x, 1'b0});
                            rec_hy[n] = HYW'({sq_y, 1'b1});
                        end
                        mso_pkg::EDGE_T:
                        begin
                            rec_hx[n] = HXW'({sq_x, 1'b1});
                            rec_hy[n] = HYW'({sq_y, 1'b0}) + HYW'(2);
                        end
                        default:
                        begin
                            rec_hx[n] = HXW'({sq_x, 1'b0}) + HXW'(2);
                            rec_hy[n] = HYW'({sq_y, 1'b1});
                        end
                    endcase
                    n = n + 1'b1;
                end
                if (edg == mso_pkg::EDGE_T)
                begin
                    has_t = 1'b1;
                    t_id  = vid[e];
                end
                if (edg == mso_pkg::EDGE_R)
                begin
                    has_r = 1'b1;
                    r_id  = vid[e];
                end
            end
        end
        // segments: entries 0-1, then 2-3
        for (int p = 0; p < 2; p++)
        begin
            if (3'(2 * p + 1) < len)
            begin
                rec_seg[n] = 1'b1;
                rec_a[n]   = vid[2 * p];
                rec_b[n]   = vid[2 * p + 1];
                rec_ovf[n] = ovf;
                n = n + 1'b1;
            end
        end
    end

    assign top_we    = xfer && has_sq;
    assign top_waddr = sq_x;
    assign top_wdata = {has_t, t_id};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_cur_reg   <= 1'b0;
            prev_above_reg <= 1'b0;
            lr_valid_reg   <= 1'b0;
            lr_id_reg      <= '0;
            vcount_reg     <= '0;
            ovf_seen_reg   <= 1'b0;
        end
        else if (restart)
        begin
            prev_cur_reg   <= 1'b0;
            prev_above_reg <= 1'b0;
            lr_valid_reg   <= 1'b0;
            lr_id_reg      <= '0;
            vcount_reg     <= '0;
            ovf_seen_reg   <= 1'b0;
        end
        else if (xfer)
        begin
            prev_cur_reg   <= s1_eol_reg ? 1'b0 : s1_bit_reg;
            prev_above_reg <= s1_eol_reg ? 1'b0 : map_rdata;
            if (has_sq)
            begin
                lr_id_reg <= r_id;
            end
            lr_valid_reg   <= s1_eol_reg ? 1'b0 : (has_sq ? has_r : lr_valid_reg);
            vcount_reg     <= s1_eog_reg ? '0 : cnt;
            ovf_seen_reg   <= s1_eog_reg ? 1'b0 : ovf;
        end
    end

    // ---------------- record buffer ----------------
    logic                  buf_seg_reg [NR];
    logic [INDEX_BITS-1:0] buf_a_reg   [NR];
    logic [INDEX_BITS-1:0] buf_b_reg   [NR];
    logic [HXW-1:0]        buf_hx_reg  [NR];
    logic [HYW-1:0]        buf_hy_reg  [NR];
    logic                  buf_ovf_reg [NR];
    logic [NW-1:0]         buf_cnt_reg;
    logic [NW-1:0]         buf_ptr_reg;
    logic                  buf_last;
    logic                  buf_free;
    logic                  out_load;
    logic                  out_valid_reg;

    assign buf_last = (buf_ptr_reg == buf_cnt_reg - 1'b1);
    assign out_load = (buf_cnt_reg != '0) && (!out_valid_reg || out_ch.ready);
    assign buf_free = (buf_cnt_reg == '0) || (out_load && buf_last);
    assign xfer     = s1_valid_reg && buf_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_cnt_reg <= '0;
            buf_ptr_reg <= '0;
        end
        else if (xfer)
        begin
            buf_cnt_reg <= n;
            buf_ptr_reg <= '0;
        end
        else if (out_load)
        begin
            if (buf_last)
            begin
                buf_cnt_reg <= '0;
                buf_ptr_reg <= '0;
            end
            else
            begin
                buf_ptr_reg <= buf_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (xfer)
        begin
            for (int k = 0; k < NR; k++)
            begin
                buf_seg_reg[k] <= rec_seg[k];
                buf_a_reg[k]   <= rec_a[k];
                buf_b_reg[k]   <= rec_b[k];
                buf_hx_reg[k]  <= rec_hx[k];
                buf_hy_reg[k]  <= rec_hy[k];
                buf_ovf_reg[k] <= rec_ovf[k];
            end
        end
    end

    // ---------------- output register with position multiply ----------------
    logic [PXW-1:0] prod_x;
    logic [PYW-1:0] prod_y;

    // half-cell count times cell size, then drop the half LSB
    assign prod_x = PXW'(buf_hx_reg[buf_ptr_reg]) * PXW'(cell_scale_reg);
    assign prod_y = PYW'(buf_hy_reg[buf_ptr_reg]) * PYW'(cell_scale_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_ch.is_segment     <= buf_seg_reg[buf_ptr_reg];
            out_ch.first_index    <= mso_pkg::IDX_FIELD_W'(buf_a_reg[buf_ptr_reg]);
            out_ch.second_index   <= mso_pkg::IDX_FIELD_W'(buf_b_reg[buf_ptr_reg]);
            out_ch.pos_x          <= buf_seg_reg[buf_ptr_reg] ? '0 :
                                     mso_pkg::POS_W'(prod_x >> 1);
            out_ch.pos_y          <= buf_seg_reg[buf_ptr_reg] ? '0 :
                                     mso_pkg::POS_W'(prod_y >> 1);
            out_ch.index_overflow <= buf_ovf_reg[buf_ptr_reg];
            out_ch.last           <= buf_last;
        end
    end

    assign out_ch.valid = out_valid_reg;

`ifndef SYNTH
    a_buf_bound: assert property (@(posedge clk) disable iff (!rst_n)
        buf_cnt_reg <= NW'(NR))
        else $error("record buffer count out of range");

    a_map_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
        (xfer && in_accept) |-> (s1_col_reg != col_reg))
        else $error("row memory read and write hit the same column");

    a_top_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
        (top_we && in_accept && col_reg != '0) |-> (top_waddr != top_raddr))
        else $error("vertex memory read and write hit the same column");

    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        restart |=> (col_reg == '0 && row_reg == '0 && vcount_reg == '0 && !lr_valid_reg))
        else $error("grid restart left state behind");
`endif
endmodule
